/* rtl/assert_macros.svh */
// Assertion macros shared by the line editor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk while i_rst_n is high.
`define LEIB_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising edge of i_clk, during reset too.
`define LEIB_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/leib_pkg.sv */
// Package with types and key codes of the line editing input buffer.
`timescale 1ns / 1ps
package leib_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;

    localparam logic [7:0] KEY_NUL  = 8'h00;
    localparam logic [7:0] KEY_CR   = 8'h0D;
    localparam logic [7:0] KEY_NL   = 8'h0A;
    localparam logic [7:0] KEY_EOF  = 8'h04;
    localparam logic [7:0] KEY_KILL = 8'h15;
    localparam logic [7:0] KEY_BS   = 8'h08;
    localparam logic [7:0] KEY_DEL  = 8'h7F;
    localparam logic [7:0] KEY_DUMP = 8'h10;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [6:0] ERASE_MAX = 7'd127;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic [6:0] erase_count;
        logic       dump_request;
        logic       line_ready;
        logic       read_valid;
        logic [7:0] read_char;
        logic       read_end;
        logic       read_eof;
        logic       read_empty;
    } t_result;

endpackage

/* rtl/leib_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module leib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/line_editing_input_buffer.sv */
// Top level of the canonical line editor over a ring of bytes.
// A keystroke result is in the output register the cycle after acceptance; a
// read result passes first through the registered line memory read, then the output register.
// Throughput: one keystroke per cycle, given a consumer that takes results as
// they appear; no new item is accepted while a read request is in S_READ.
// Reset clears the read, commit and edit indices and the output valid; the line
// memory is not cleared, since only committed entries are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module line_editing_input_buffer #(
    parameter int BUFFER_DEPTH = leib_pkg::BUFFER_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_key_code,
    input  logic       i_read_started,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_char,
    output logic [6:0] o_erase_count,
    output logic       o_dump_request,
    output logic       o_line_ready,
    output logic       o_read_valid,
    output logic [7:0] o_read_char,
    output logic       o_read_end,
    output logic       o_read_eof,
    output logic       o_read_empty
);
    import leib_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int IW = AW + 1;
    localparam int CW = (IW > 7) ? IW : 7;
    localparam logic [IW:0]   MOD_W   = (IW + 1)'(2 * BUFFER_DEPTH);
    localparam logic [IW-1:0] IDX_MAX = IW'(2 * BUFFER_DEPTH - 1);
    localparam logic [IW-1:0] DEPTH_W = IW'(BUFFER_DEPTH);

    // Indices run modulo twice the depth so that full and empty differ.
    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
        return (x == IDX_MAX) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
        return (x == '0) ? IDX_MAX : x - 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a,
                                               input logic [IW-1:0] b);
        return (a >= b) ? a - b : a - b + MOD_W[IW-1:0];
    endfunction

    function automatic logic [AW-1:0] idx_addr(input logic [IW-1:0] x);
        logic [IW-1:0] v;
        v = (x >= DEPTH_W) ? x - DEPTH_W : x;
        return v[AW-1:0];
    endfunction

    t_state        r_state, n_state;
    t_result       r_res, n_res;
    logic          r_out_valid, n_out_valid;
    logic          r_started, n_started;
    logic [IW-1:0] r_read_idx, n_read_idx;
    logic [IW-1:0] r_commit_idx, n_commit_idx;
    logic [IW-1:0] r_edit_idx, n_edit_idx;

    logic          in_acc;
    logic          we;
    logic [7:0]    wdata;
    logic [7:0]    rd_data;
    logic [7:0]    key;
    logic [IW-1:0] edit_inc;
    logic [CW-1:0] kill_cnt;
    logic [IW-1:0] fill_rc;
    logic [IW-1:0] fill_er;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign edit_inc   = idx_inc(r_edit_idx);
    assign kill_cnt   = CW'(idx_diff(r_edit_idx, r_commit_idx));
    assign fill_rc    = idx_diff(r_commit_idx, r_read_idx);
    assign fill_er    = idx_diff(r_edit_idx, r_read_idx);
    assign key        = (i_key_code == KEY_CR) ? KEY_NL : i_key_code;

    // Keystrokes write the memory only in S_IDLE and reads use the data only in
    // S_READ, where no item is accepted, so a read never meets a write in flight.
    leib_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (idx_addr(r_edit_idx)),
        .i_wdata (wdata),
        .i_raddr (idx_addr(r_read_idx)),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_started    = r_started;
        n_read_idx   = r_read_idx;
        n_commit_idx = r_commit_idx;
        n_edit_idx   = r_edit_idx;
        we           = 1'b0;
        wdata        = key;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_kind == KIND_READ) begin
                        n_state   = S_READ;
                        n_started = i_read_started;
                    end else begin
                        n_res       = '0;
                        n_out_valid = 1'b1;
                        if (i_key_code == KEY_DUMP) begin
                            n_res.dump_request = 1'b1;
                        end else if (i_key_code == KEY_KILL) begin
                            n_edit_idx = r_commit_idx;
                            n_res.erase_count = (kill_cnt > CW'(ERASE_MAX)) ?
                                                ERASE_MAX : kill_cnt[6:0];
                        end else if (i_key_code == KEY_BS || i_key_code == KEY_DEL) begin
                            if (r_edit_idx != r_commit_idx) begin
                                n_edit_idx        = idx_dec(r_edit_idx);
                                n_res.erase_count = 7'd1;
                            end
                        end else if (i_key_code != KEY_NUL && fill_er < DEPTH_W) begin
                            we               = 1'b1;
                            n_edit_idx       = edit_inc;
                            n_res.echo_valid = 1'b1;
                            n_res.echo_char  = key;
                            if (key == KEY_NL || key == KEY_EOF ||
                                idx_diff(edit_inc, r_read_idx) == DEPTH_W) begin
                                n_commit_idx     = edit_inc;
                                n_res.line_ready = 1'b1;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_res       = '0;
                if (r_read_idx == r_commit_idx) begin
                    n_res.read_empty = 1'b1;
                end else if (rd_data == KEY_EOF) begin
                    // The end-of-file mark stays for the next read call if this
                    // call already delivered bytes.
                    n_res.read_eof = 1'b1;
                    n_res.read_end = 1'b1;
                    if (!r_started) begin
                        n_read_idx = idx_inc(r_read_idx);
                    end
                end else begin
                    n_read_idx       = idx_inc(r_read_idx);
                    n_res.read_valid = 1'b1;
                    n_res.read_char  = rd_data;
                    n_res.read_end   = (rd_data == KEY_NL);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_read_idx   <= '0;
            r_commit_idx <= '0;
            r_edit_idx   <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_read_idx   <= n_read_idx;
            r_commit_idx <= n_commit_idx;
            r_edit_idx   <= n_edit_idx;
        end
        r_res     <= n_res;
        r_started <= n_started;
    end

    assign o_out_valid    = r_out_valid;
    assign o_echo_valid   = r_res.echo_valid;
    assign o_echo_char    = r_res.echo_char;
    assign o_erase_count  = r_res.erase_count;
    assign o_dump_request = r_res.dump_request;
    assign o_line_ready   = r_res.line_ready;
    assign o_read_valid   = r_res.read_valid;
    assign o_read_char    = r_res.read_char;
    assign o_read_end     = r_res.read_end;
    assign o_read_eof     = r_res.read_eof;
    assign o_read_empty   = r_res.read_empty;

    `LEIB_CHECK(a_index_order, (fill_rc <= fill_er) && (fill_er <= DEPTH_W), "ring indices out of order")
    `LEIB_CHECK(a_key_result, (in_acc && i_kind == KIND_KEY) |=> r_out_valid, "keystroke gave no result")
    `LEIB_CHECK(a_read_result, (in_acc && i_kind == KIND_READ) |=> ##1 r_out_valid, "read gave no result")
    `LEIB_CHECK(a_no_write_in_read, (r_state == S_READ) |-> !we, "memory written during a read")
    `LEIB_CHECK_ALWAYS(a_one_result, (r_res.read_empty && r_out_valid) |-> !r_res.read_valid, "empty read with data")

endmodule
